/* hw/rtl/stb_pkg.sv */
// Shared types and constants for the software timer slot bank.
// Used by the channel interfaces, controller, datapath, top level and checker.
package stb_pkg;

  // Slot count bounds and default
  localparam int unsigned SlotCountDefault = 8;
  localparam int unsigned SlotIdxMaxW      = 5;

  // Field widths of the channels
  localparam int unsigned OpW         = 2;
  localparam int unsigned CountW      = 32;
  localparam int unsigned SlotIndexW  = 3;
  localparam int unsigned FiredMaskW  = 8;
  localparam int unsigned TickW       = 10;

  // Configuration port
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;
  localparam logic [0:0]  RegTickLength   = 1'b0;
  localparam logic [TickW-1:0] TickLengthReset = 10'd10;

  // Item operation codes
  typedef enum logic [OpW-1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_RESULT
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic                   latch_in;
    logic                   start_exec;
    logic                   clear_exec;
    logic                   rd_en;
    logic [SlotIdxMaxW-1:0] rd_addr;
    logic                   tick_step;
    logic [SlotIdxMaxW-1:0] step_idx;
    logic                   tick_done;
    logic                   load_result;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [OpW-1:0] op;
  } status_t;

endpackage

/* hw/rtl/stb_req_if.sv */
// Request channel of the timer slot bank: one item per op.
// Depends on stb_pkg for field widths.
interface stb_req_if import stb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OpW-1:0]    op;
  logic [CountW-1:0] duration_ms;
  logic              periodic;

  modport source (output valid, output op, output duration_ms, output periodic, input ready);
  modport sink   (input valid, input op, input duration_ms, input periodic, output ready);
endinterface

/* hw/rtl/stb_rsp_if.sv */
// Result channel of the timer slot bank: one result item per request item.
// Depends on stb_pkg for field widths.
interface stb_rsp_if import stb_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [SlotIndexW-1:0] slot_index;
  logic                  accepted;
  logic [FiredMaskW-1:0] fired_mask;
  logic [CountW-1:0]     elapsed_ms;

  modport source (output valid, output slot_index, output accepted, output fired_mask,
                  output elapsed_ms, input ready);
  modport sink   (input valid, input slot_index, input accepted, input fired_mask,
                  input elapsed_ms, output ready);
endinterface

/* hw/rtl/software_timer_slot_bank.sv */
// Top level of the timer slot bank: channels, tick length register, controller and datapath.
// Depends on stb_pkg, stb_req_if, stb_rsp_if, stb_ctrl and stb_datapath.
//
//   channel | direction | handshake        | payload
//   req_i   | in        | valid / ready    | op, duration_ms, periodic
//   rsp_o   | out       | valid / ready    | slot_index, accepted, fired_mask, elapsed_ms
//   apb     | in        | psel, penable    | paddr, pwdata, prdata (tick_length_ms at 0x0)
//
// A tick item passes through DISPATCH, SCAN and RESULT from acceptance to result:
// the scan visits one slot per cycle through the single write port of the count memory.
// Start, clear and unused op items pass through DISPATCH and RESULT. One item is worked on at a time; the
// next is taken while the previous result waits in the output register.
// Reset is asynchronous and needs no clearing pass; a stalled result holds its register.
module software_timer_slot_bank import stb_pkg::*; #(
  parameter int unsigned SLOT_COUNT = SlotCountDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  stb_req_if.sink             req_i,
  stb_rsp_if.source           rsp_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  logic [TickW-1:0] tick_length_q, tick_length_d;
  logic             cfg_wr;
  logic [0:0]       reg_idx;
  cmd_t             cmd;
  status_t          status;

  // Tick length register
  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_comb begin
    tick_length_d = tick_length_q;
    if (cfg_wr && (reg_idx == RegTickLength)) begin
      tick_length_d = pwdata[TickW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_length_q <= TickLengthReset;
    end else begin
      tick_length_q <= tick_length_d;
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    if (reg_idx == RegTickLength) begin
      prdata = ApbDataW'(tick_length_q);
    end
  end

  stb_ctrl #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  stb_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .tick_length_i (tick_length_q),
    .op_i          (req_i.op),
    .duration_ms_i (req_i.duration_ms),
    .periodic_i    (req_i.periodic),
    .slot_index_o  (rsp_o.slot_index),
    .accepted_o    (rsp_o.accepted),
    .fired_mask_o  (rsp_o.fired_mask),
    .elapsed_ms_o  (rsp_o.elapsed_ms)
  );

endmodule

/* hw/rtl/stb_ctrl.sv */
// Controller of the timer slot bank: sequences start, clear and the slot scan of a tick.
// Depends on stb_pkg; drives the datapath through cmd_t and reads status_t.
module stb_ctrl import stb_pkg::*; #(
  parameter int unsigned SLOT_COUNT = SlotCountDefault
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    req_valid_i,
  output logic    req_ready_o,
  output logic    rsp_valid_o,
  input  logic    rsp_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  localparam int unsigned SlotIdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [SlotIdxW-1:0] LastIdx = SlotIdxW'(SLOT_COUNT - 1);

  state_e              state_q, state_d;
  logic [SlotIdxW-1:0] idx_q, idx_d;
  logic                rsp_valid_q, rsp_valid_d;
  logic [SlotIdxW-1:0] idx_next;

  // State, scan index and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  assign idx_next = SlotIdxW'(idx_q + 1'b1);

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    rsp_valid_d = rsp_valid_q & ~rsp_ready_i;
    cmd_o       = '0;
    req_ready_o = 1'b0;

    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (status_i.op)
          OP_TICK: begin
            // prime the read of slot 0
            cmd_o.rd_en   = 1'b1;
            cmd_o.rd_addr = '0;
            idx_d         = '0;
            state_d       = ST_SCAN;
          end
          OP_START: begin
            cmd_o.start_exec = 1'b1;
            state_d          = ST_RESULT;
          end
          OP_CLEAR: begin
            cmd_o.clear_exec = 1'b1;
            state_d          = ST_RESULT;
          end
          default: begin
            state_d = ST_RESULT;
          end
        endcase
      end
      ST_SCAN: begin
        // update slot idx while reading the next one
        cmd_o.tick_step = 1'b1;
        cmd_o.step_idx  = SlotIdxMaxW'(idx_q);
        if (idx_q == LastIdx) begin
          cmd_o.tick_done = 1'b1;
          state_d         = ST_RESULT;
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = SlotIdxMaxW'(idx_next);
          idx_d         = idx_next;
        end
      end
      ST_RESULT: begin
        // load the output register once it is free
        if (!rsp_valid_q || rsp_ready_i) begin
          cmd_o.load_result = 1'b1;
          rsp_valid_d       = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign rsp_valid_o = rsp_valid_q;

endmodule

/* hw/rtl/stb_datapath.sv */
// Datapath of the timer slot bank: count and reload memories, slot masks, elapsed count.
// Depends on stb_pkg; commanded by stb_ctrl.
module stb_datapath import stb_pkg::*; #(
  parameter int unsigned SLOT_COUNT = SlotCountDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  output status_t               status_o,
  input  logic [TickW-1:0]      tick_length_i,
  input  logic [OpW-1:0]        op_i,
  input  logic [CountW-1:0]     duration_ms_i,
  input  logic                  periodic_i,
  output logic [SlotIndexW-1:0] slot_index_o,
  output logic                  accepted_o,
  output logic [FiredMaskW-1:0] fired_mask_o,
  output logic [CountW-1:0]     elapsed_ms_o
);

  localparam int unsigned SlotIdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // Slot count and reload memories
  logic [CountW-1:0] rem_mem [SLOT_COUNT];
  logic [CountW-1:0] rel_mem [SLOT_COUNT];
  logic [CountW-1:0] rem_rd_q, rel_rd_q;

  // Latched item
  logic [OpW-1:0]    op_q;
  logic [CountW-1:0] duration_q;
  logic              periodic_in_q;

  // Slot state and result under construction
  logic [SLOT_COUNT-1:0] busy_q, busy_d;
  logic [SLOT_COUNT-1:0] periodic_q, periodic_d;
  logic [SLOT_COUNT-1:0] fired_q, fired_d;
  logic [CountW-1:0]     elapsed_q, elapsed_d;
  logic [SlotIdxW-1:0]   slot_q, slot_d;
  logic                  accepted_q, accepted_d;

  // Output register
  logic [SlotIndexW-1:0] rsp_slot_q;
  logic                  rsp_accepted_q;
  logic [FiredMaskW-1:0] rsp_fired_q;
  logic [CountW-1:0]     rsp_elapsed_q;

  logic                any_free;
  logic [SlotIdxW-1:0] free_idx;
  logic [SlotIdxW-1:0] rd_idx, step_idx;
  logic [CountW-1:0]   tick32;
  logic                step_busy, step_periodic, expire;
  logic                start_wr, step_wr;
  logic [CountW-1:0]   step_val;
  logic [31:0]         slot_wide, fired_wide;

  assign rd_idx        = cmd_i.rd_addr[SlotIdxW-1:0];
  assign step_idx      = cmd_i.step_idx[SlotIdxW-1:0];
  assign tick32        = CountW'(tick_length_i);
  assign step_busy     = busy_q[step_idx];
  assign step_periodic = periodic_q[step_idx];
  assign expire        = (rem_rd_q <= tick32);
  assign step_val      = expire ? rel_rd_q : (rem_rd_q - tick32);
  assign start_wr      = cmd_i.start_exec & any_free;
  // an expiring one-shot slot is freed and needs no count write
  assign step_wr       = cmd_i.tick_step & step_busy & (~expire | step_periodic);

  // Find the lowest free slot
  always_comb begin
    any_free = 1'b0;
    free_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!busy_q[i]) begin
        any_free = 1'b1;
        free_idx = SlotIdxW'(i);
      end
    end
  end

  // Memory write and registered read
  always_ff @(posedge clk_i) begin
    if (start_wr) begin
      rem_mem[free_idx] <= duration_q;
    end else if (step_wr) begin
      rem_mem[step_idx] <= step_val;
    end
    if (start_wr && periodic_in_q) begin
      rel_mem[free_idx] <= duration_q;
    end
    if (cmd_i.rd_en) begin
      rem_rd_q <= rem_mem[rd_idx];
      rel_rd_q <= rel_mem[rd_idx];
    end
  end

  // Latch the accepted item
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      op_q          <= op_i;
      duration_q    <= duration_ms_i;
      periodic_in_q <= periodic_i;
    end
  end

  // Next slot state
  always_comb begin
    busy_d     = busy_q;
    periodic_d = periodic_q;
    fired_d    = fired_q;
    elapsed_d  = elapsed_q;
    slot_d     = slot_q;
    accepted_d = accepted_q;

    if (cmd_i.latch_in) begin
      fired_d    = '0;
      slot_d     = '0;
      accepted_d = 1'b0;
    end
    if (start_wr) begin
      busy_d[free_idx]     = 1'b1;
      periodic_d[free_idx] = periodic_in_q;
      slot_d               = free_idx;
      accepted_d           = 1'b1;
    end
    if (cmd_i.tick_step && step_busy && expire) begin
      fired_d[step_idx] = 1'b1;
      if (!step_periodic) begin
        busy_d[step_idx] = 1'b0;
      end
    end
    if (cmd_i.tick_done) begin
      elapsed_d = elapsed_q + tick32;
    end
    if (cmd_i.clear_exec) begin
      elapsed_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= '0;
      periodic_q <= '0;
      fired_q    <= '0;
      elapsed_q  <= '0;
      slot_q     <= '0;
      accepted_q <= 1'b0;
    end else begin
      busy_q     <= busy_d;
      periodic_q <= periodic_d;
      fired_q    <= fired_d;
      elapsed_q  <= elapsed_d;
      slot_q     <= slot_d;
      accepted_q <= accepted_d;
    end
  end

  // Fit slot number and fired mask to the result field widths
  assign slot_wide  = 32'(slot_q);
  assign fired_wide = 32'(fired_q);

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      rsp_slot_q     <= slot_wide[SlotIndexW-1:0];
      rsp_accepted_q <= accepted_q;
      rsp_fired_q    <= fired_wide[FiredMaskW-1:0];
      rsp_elapsed_q  <= elapsed_q;
    end
  end

  assign status_o.op  = op_q;
  assign slot_index_o = rsp_slot_q;
  assign accepted_o   = rsp_accepted_q;
  assign fired_mask_o = rsp_fired_q;
  assign elapsed_ms_o = rsp_elapsed_q;

endmodule

/* hw/rtl/stb_checker.sv */
// Port-level checks of the timer slot bank, attached to the top level by bind.
// Depends on stb_pkg for field widths.
module stb_checker import stb_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  req_valid_i,
  input logic                  req_ready_i,
  input logic                  rsp_valid_i,
  input logic                  rsp_ready_i,
  input logic [SlotIndexW-1:0] slot_index_i,
  input logic                  accepted_i,
  input logic [FiredMaskW-1:0] fired_mask_i,
  input logic [CountW-1:0]     elapsed_ms_i
);

  // Hold a stalled result
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(slot_index_i)
      && $stable(accepted_i) && $stable(fired_mask_i) && $stable(elapsed_ms_i))
    else $error("result changed while stalled");

  // A refused or non-start item reports slot zero
  a_refused_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !accepted_i |-> slot_index_i == '0)
    else $error("slot index set without a granted start");

  // A granted start fires no slot
  a_start_no_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && accepted_i |-> fired_mask_i == '0)
    else $error("fired mask set on a granted start");

  // One item at a time: no item is taken right after another
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken in back-to-back cycles");

endmodule

bind software_timer_slot_bank stb_checker u_stb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .slot_index_i (rsp_o.slot_index),
  .accepted_i   (rsp_o.accepted),
  .fired_mask_i (rsp_o.fired_mask),
  .elapsed_ms_i (rsp_o.elapsed_ms)
);

/* test/stb_timer_checker.sv */
`timescale 1ns / 100ps
// Result checker for the timer slot bank: mirrors slot counts, masks and elapsed count,
// predicts one result item per request item and compares in order.
// Depends on stb_pkg, stb_req_if and stb_rsp_if.
module stb_timer_checker import stb_pkg::*; #(
  parameter int unsigned SLOT_COUNT = SlotCountDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  stb_req_if                  req_mon,
  stb_rsp_if                  rsp_mon,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic [ApbAddrW-1:0] paddr_i,
  input  logic [ApbDataW-1:0] pwdata_i,
  input  logic                pready_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  localparam logic [ApbAddrW-1:0] TickLengthAddr = ApbAddrW'(4 * RegTickLength);
  localparam int MaxReports = 10;

  typedef struct packed {
    logic [SlotIndexW-1:0] slot_index;
    logic                  accepted;
    logic [FiredMaskW-1:0] fired_mask;
    logic [CountW-1:0]     elapsed_ms;
  } timer_result_t;

  // Mirrored bank state
  logic [CountW-1:0]     count_left [SLOT_COUNT];
  logic [CountW-1:0]     reload_val [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] busy_slots;
  logic [SLOT_COUNT-1:0] periodic_slots;
  logic [CountW-1:0]     elapsed_total;
  logic [TickW-1:0]      tick_len;

  timer_result_t awaited_results [$];
  int            reported;

  // Apply one item to the mirrored bank and return the result it produces
  function automatic timer_result_t next_timer_result(logic [OpW-1:0] op,
                                                      logic [CountW-1:0] duration,
                                                      logic periodic);
    timer_result_t         res;
    logic [SLOT_COUNT-1:0] fired;
    logic                  granted;
    res     = '0;
    fired   = '0;
    granted = 1'b0;
    case (op)
      OP_TICK: begin
        // Fire at or below one tick, otherwise count down
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (busy_slots[i]) begin
            if (count_left[i] <= CountW'(tick_len)) begin
              fired[i] = 1'b1;
              if (periodic_slots[i]) begin
                count_left[i] = reload_val[i];
              end else begin
                busy_slots[i] = 1'b0;
                count_left[i] = '0;
              end
            end else begin
              count_left[i] = count_left[i] - CountW'(tick_len);
            end
          end
        end
        elapsed_total = elapsed_total + CountW'(tick_len);
      end
      OP_START: begin
        // Claim the lowest free slot
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (!granted && !busy_slots[i]) begin
            busy_slots[i] = 1'b1;
            count_left[i] = duration;
            if (periodic) begin
              reload_val[i]     = duration;
              periodic_slots[i] = 1'b1;
            end else begin
              periodic_slots[i] = 1'b0;
            end
            res.slot_index = SlotIndexW'(i);
            res.accepted   = 1'b1;
            granted        = 1'b1;
          end
        end
      end
      OP_CLEAR: begin
        elapsed_total = '0;
      end
      default: begin
      end
    endcase
    res.fired_mask = FiredMaskW'(fired);
    res.elapsed_ms = elapsed_total;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    timer_result_t seen;
    timer_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        count_left[i] = '0;
        reload_val[i] = '0;
      end
      busy_slots     = '0;
      periodic_slots = '0;
      elapsed_total  = '0;
      tick_len       = TickLengthReset;
      awaited_results.delete();
      reported       = 0;
      fail_count_o   = 0;
      pending_o      = 0;
    end else begin
      // Compare each accepted result item with the oldest prediction
      if (rsp_mon.valid && rsp_mon.ready) begin
        seen.slot_index = rsp_mon.slot_index;
        seen.accepted   = rsp_mon.accepted;
        seen.fired_mask = rsp_mon.fired_mask;
        seen.elapsed_ms = rsp_mon.elapsed_ms;
        if (awaited_results.size() == 0) begin
          fail_count_o++;
          if (reported < MaxReports) begin
            $display("%0t: unexpected result item: slot %0d accepted %0b fired %02h elapsed %0d",
                     $realtime, seen.slot_index, seen.accepted, seen.fired_mask,
                     seen.elapsed_ms);
          end
          reported++;
        end else begin
          want = awaited_results.pop_front();
          if (seen !== want) begin
            fail_count_o++;
            if (reported < MaxReports) begin
              $display("%0t: result mismatch: expected slot %0d accepted %0b fired %02h elapsed %0d",
                       $realtime, want.slot_index, want.accepted, want.fired_mask,
                       want.elapsed_ms);
              $display("%0t:                  actual   slot %0d accepted %0b fired %02h elapsed %0d",
                       $realtime, seen.slot_index, seen.accepted, seen.fired_mask,
                       seen.elapsed_ms);
            end
            reported++;
          end
        end
      end

      // Predict the result of each accepted request item
      if (req_mon.valid && req_mon.ready) begin
        awaited_results.push_back(next_timer_result(req_mon.op, req_mon.duration_ms,
                                                    req_mon.periodic));
      end

      // Track tick length writes
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == TickLengthAddr) begin
        tick_len = pwdata_i[TickW-1:0];
      end

      pending_o = awaited_results.size();
    end
  end

endmodule

/* test/software_timer_slot_bank_tb.sv */
`timescale 1ns / 100ps
// Testbench top for the timer slot bank: clock, reset, request and tick length stimulus,
// receiver stalls and the verdict. Depends on stb_pkg, stb_req_if, stb_rsp_if,
// software_timer_slot_bank and stb_timer_checker.
module software_timer_slot_bank_tb;
  import stb_pkg::*;

  localparam logic [OpW-1:0]      OpUnused       = 2'd3;
  localparam logic [ApbAddrW-1:0] TickLengthAddr = ApbAddrW'(4 * RegTickLength);
  localparam int                  LongHoldCycles = 200;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  int               fail_count;
  int               pending_results;
  int               send_idle_pct;
  int               rsp_stall_pct;
  logic             long_hold_req;
  logic [TickW-1:0] tick_setting;
  int               periodic_budget;

  stb_req_if req_if ();
  stb_rsp_if rsp_if ();

  software_timer_slot_bank u_top (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  stb_timer_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .req_mon      (req_if),
    .rsp_mon      (rsp_if),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .pready_i     (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending_results)
  );

  always #4 clk = ~clk;

  // Result receiver: random stalls, or one long hold-off on request
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        rsp_if.ready <= 1'b0;
        repeat (LongHoldCycles) @(negedge clk);
        long_hold_req = 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
    end
  end

  // Offer one request item, with optional idle cycles ahead of it
  task automatic send_item(logic [OpW-1:0] op, logic [CountW-1:0] duration, logic periodic);
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req_if.valid       <= 1'b1;
    req_if.op          <= op;
    req_if.duration_ms <= duration;
    req_if.periodic    <= periodic;
    do @(posedge clk); while (!req_if.ready);
  endtask

  // Stop offering and wait until every result item is back
  task automatic drain_results();
    @(negedge clk);
    req_if.valid <= 1'b0;
    wait (pending_results == 0);
  endtask

  task automatic write_tick_length(logic [TickW-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TickLengthAddr;
    pwdata  <= ApbDataW'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tick_setting = value;
  endtask

  // Durations near the tick length so that slots expire within a few ticks
  function automatic logic [CountW-1:0] pick_duration();
    int unsigned r;
    int unsigned tl;
    int unsigned d;
    r  = $urandom_range(99);
    tl = 32'(tick_setting);
    if (r < 10) return '0;
    if (r < 30) begin
      d = tl + $urandom_range(2);
      return CountW'((d == 0) ? 0 : d - 1);
    end
    return CountW'($urandom_range(6 * tl + 5));
  endfunction

  task automatic send_random_item();
    int                pick;
    logic [CountW-1:0] noise;
    logic              per;
    pick  = $urandom_range(99);
    noise = $urandom();
    per   = 1'($urandom_range(1));
    if (pick < 45) begin
      send_item(OP_TICK, noise, per);
    end else if (pick < 87) begin
      // Periodic slots never free, so hand them out sparingly
      per = 1'b0;
      if (periodic_budget > 0 && $urandom_range(15) == 0) begin
        per = 1'b1;
        periodic_budget--;
      end
      send_item(OP_START, pick_duration(), per);
    end else if (pick < 96) begin
      send_item(OP_CLEAR, noise, per);
    end else begin
      send_item(OpUnused, noise, per);
    end
  endtask

  task automatic run_phase(int items, int send_pct, int stall_pct);
    send_idle_pct = send_pct;
    rsp_stall_pct = stall_pct;
    repeat (items) send_random_item();
  endtask

  initial begin
    logic [CountW-1:0] fill_counts [7];
    fill_counts = '{32'd9, 32'd10, 32'd11, 32'd0, 32'd20, 32'd30, 32'd1000};

    rst_n              = 1'b0;
    req_if.valid       = 1'b0;
    req_if.op          = OP_TICK;
    req_if.duration_ms = '0;
    req_if.periodic    = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    send_idle_pct      = 0;
    rsp_stall_pct      = 0;
    long_hold_req      = 1'b0;
    tick_setting       = TickLengthReset;
    periodic_budget    = 0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty bank, unused op, zero duration, periodic zero reload, full bank
    send_item(OP_CLEAR, '0, 1'b0);
    send_item(OpUnused, '1, 1'b1);
    send_item(OP_TICK, '0, 1'b0);
    send_item(OP_START, '0, 1'b0);
    send_item(OP_TICK, '1, 1'b1);
    send_item(OP_START, '0, 1'b1);
    foreach (fill_counts[k]) send_item(OP_START, fill_counts[k], 1'b0);
    send_item(OP_START, 32'd5, 1'b1);
    repeat (3) send_item(OP_TICK, '0, 1'b0);
    send_item(OP_CLEAR, '1, 1'b0);
    send_item(OP_TICK, '0, 1'b0);

    // Shortest non-zero tick, no idling
    drain_results();
    write_tick_length(10'd1);
    run_phase(440, 0, 0);

    // Longest tick in range, sender idling
    drain_results();
    write_tick_length(10'd1000);
    periodic_budget = 1;
    run_phase(440, 45, 0);

    // Random tick, receiver stalling; hold off early so the bank backs up
    drain_results();
    write_tick_length(10'($urandom_range(1000, 1)));
    periodic_budget = 2;
    long_hold_req   = 1'b1;
    run_phase(440, 0, 45);

    // Zero tick: only zero counts fire
    drain_results();
    write_tick_length(10'd0);
    run_phase(60, 32, 32);

    // Widest tick the register holds, both sides idling
    drain_results();
    write_tick_length(10'h3FF);
    periodic_budget = 2;
    run_phase(220, 32, 32);
    drain_results();
    run_phase(220, 32, 32);

    // Full-width durations last, since such slots stay busy for good
    repeat (12) begin
      send_item(OP_START, $urandom(), 1'($urandom_range(1)));
      send_item(OP_TICK, $urandom(), 1'b0);
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("software_timer_slot_bank_tb: clean");
    end else begin
      $display("software_timer_slot_bank_tb: errors");
    end
    $finish;
  end

  // Timeout guard
  initial begin
    #5000000;
    $display("software_timer_slot_bank_tb: errors");
    $finish;
  end

endmodule
